[sv/sfn_pkg.sv]
// ----------------------------------------------------------------------------
// Surface normal package
// Shared constants and codes for the surface normal unit.
// ----------------------------------------------------------------------------
package sfn_pkg;

	localparam int WORDS = 18;
	localparam int ACC_W = 67;
	localparam int RAD_W = 64;
	localparam int ROOT_W = 32;
	localparam int NUM_W = 61;
	localparam int DEN_W = 31;

	localparam logic [4:0] W_TYPE = 5'd12;
	localparam logic [4:0] W_MIN = 5'd13;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_STORED   = 2'd1,
		ST_BAD_TYPE = 2'd2,
		ST_ZERO     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SH_PLANE  = 2'd0,
		SH_SPHERE = 2'd1,
		SH_CONE   = 2'd2,
		SH_CYL    = 2'd3
	} shape_t;

endpackage

[sv/sfn_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module sfn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 288
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

[sv/sfn_isqrt.sv]
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sfn_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sfn_pkg::RAD_W-1:0]   radicand,
	output logic                        done,
	output logic [sfn_pkg::ROOT_W-1:0]  root
);

	import sfn_pkg::*;

	logic [RAD_W-1:0] rem_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RAD_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

[sv/sfn_div.sv]
// ----------------------------------------------------------------------------
// Iterative restoring divider
// 61-bit by 31-bit division with a 31-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module sfn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sfn_pkg::NUM_W-1:0]  num,
	input  logic [sfn_pkg::DEN_W-1:0]  den,
	output logic                       done,
	output logic [sfn_pkg::DEN_W-1:0]  quo
);

	import sfn_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] low_q;
	logic [DEN_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, low_q[DEN_W-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DEN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num[NUM_W-1:DEN_W]};
			low_q <= num[DEN_W-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			low_q <= low_q << 1;
			quo_q <= {quo_q[DEN_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

[sv/surface_normal_unit.sv]
// One item at a time: the next item is taken once the FSM is back in idle.
// The compute time is set by the shared multiplier, the one-bit normalizing shifter,
// the 32-step square root and three 31-step divisions.
// Reset clears control state and sets epsilon to 7; the shape table is not cleared.
// ----------------------------------------------------------------------------
// Surface normal unit
// Shape table, object-space normal, world mapping and normalization, built
// around one shared multiplier, a square root unit and a divider.
// ----------------------------------------------------------------------------
module surface_normal_unit #(
	parameter int OBJECTS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [3:0]         object_id,
	input  logic [4:0]         word_index,
	input  logic signed [31:0] word_value,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] normal_x,
	output logic signed [31:0] normal_y,
	output logic signed [31:0] normal_z,
	output logic [1:0]         status
);

	import sfn_pkg::*;

	localparam int DEPTH = OBJECTS * WORDS;
	localparam int AW = $clog2(DEPTH);
	localparam logic signed [32:0] ONE = 33'(1) << FRAC_BITS;
	localparam logic [63:0] DIST_ONE = 64'(1) << (2 * FRAC_BITS);

	typedef enum logic [4:0] {
		S_IDLE, S_TY_RD, S_TY_CHK, S_PT_RD, S_PT_MUL, S_PT_ACC, S_MX_RD, S_MX_WT,
		S_D0, S_D1, S_D2, S_NSEL, S_CSQ_GO, S_CSQ_WT, S_W_RD, S_W_MUL, S_W_ACC,
		S_MAG, S_MAX, S_NSH, S_SQ_MUL, S_SQ_ACC, S_LEN_GO, S_LEN_WT, S_DV_GO,
		S_DV_WT, S_FIN
	} state_t;

	state_t state_q;

	logic [15:0]              eps_q;
	logic [AW-1:0]            base_q;
	shape_t                   type_q;
	logic [3:0]               cnt_q;
	logic [2:0]               mx_q;
	logic [1:0]               wi_q;
	logic [1:0]               wj_q;
	logic [1:0]               si_q;
	logic signed [31:0]       pt_q [3];
	logic signed [31:0]       op_q [3];
	logic signed [31:0]       aux_q [5];
	logic signed [32:0]       n_q [3];
	logic signed [ACC_W-1:0]  w_q [3];
	logic [ACC_W-1:0]         mag_q [3];
	logic [ACC_W-1:0]         m_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [64:0]       prod_q;
	logic signed [31:0]       word_q;
	logic [63:0]              dist_q;
	logic [61:0]              sum_q;
	logic [30:0]              len_q;
	logic signed [31:0]       u_q [3];
	status_t                  st_q;
	logic                     out_valid_q;
	logic signed [31:0]       nx_q;
	logic signed [31:0]       ny_q;
	logic signed [31:0]       nz_q;
	status_t                  ost_q;

	logic                     obj_ok;
	logic [AW-1:0]            in_base;
	logic                     ram_we;
	logic [AW-1:0]            ram_addr;
	logic [31:0]              ram_rdata;
	logic signed [31:0]       mul_a;
	logic signed [32:0]       mul_b;
	logic signed [64:0]       mul_p;
	logic signed [64:0]       pfl;
	logic signed [ACC_W-1:0]  pt_sum;
	logic signed [ACC_W-1:0]  w_sum;
	logic signed [33:0]       op1_x;
	logic signed [33:0]       max_lo;
	logic signed [33:0]       min_hi;
	logic                     near;
	logic                     sq_start;
	logic [RAD_W-1:0]         sq_rad;
	logic                     sq_done;
	logic [ROOT_W-1:0]        sq_root;
	logic                     dv_start;
	logic [NUM_W-1:0]         dv_num;
	logic                     dv_done;
	logic [DEN_W-1:0]         dv_quo;
	logic [DEN_W-1:0]         q_cap;
	logic signed [31:0]       u_next;

	assign obj_ok = 32'(object_id) < 32'(OBJECTS);
	assign in_base = AW'(32'(object_id) * 32'(WORDS));
	assign in_ready = (state_q == S_IDLE);
	assign ram_we = (state_q == S_IDLE) && in_valid && !mode && obj_ok
		&& (32'(word_index) < 32'(WORDS));

	always_comb begin
		case (state_q)
			S_IDLE:  ram_addr = in_base + AW'(word_index);
			S_TY_RD: ram_addr = base_q + AW'(W_TYPE);
			S_PT_RD: ram_addr = base_q + AW'(cnt_q);
			S_MX_RD: ram_addr = base_q + AW'(W_MIN) + AW'(mx_q);
			S_W_RD:  ram_addr = base_q + AW'({wi_q, 2'b00}) + AW'(wj_q);
			default: ram_addr = base_q;
		endcase
	end

	sfn_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (word_value),
		.rdata (ram_rdata)
	);

	always_comb begin
		case (state_q)
			S_PT_MUL: begin
				mul_a = $signed(ram_rdata);
				mul_b = (cnt_q[1:0] == 2'd3) ? 33'sd0
					: {pt_q[cnt_q[1:0]][31], pt_q[cnt_q[1:0]]};
			end
			S_W_MUL: begin
				mul_a = $signed(ram_rdata);
				mul_b = (wi_q == 2'd3) ? 33'sd0 : n_q[wi_q];
			end
			S_D0: begin
				mul_a = op_q[0];
				mul_b = {op_q[0][31], op_q[0]};
			end
			S_D1: begin
				mul_a = op_q[2];
				mul_b = {op_q[2][31], op_q[2]};
			end
			S_SQ_MUL: begin
				mul_a = (si_q == 2'd3) ? 32'sd0 : $signed({2'b00, mag_q[si_q][29:0]});
				mul_b = (si_q == 2'd3) ? 33'sd0 : $signed({3'b000, mag_q[si_q][29:0]});
			end
			default: begin
				mul_a = 32'sd0;
				mul_b = 33'sd0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign pfl = prod_q >>> FRAC_BITS;
	assign pt_sum = acc_q + ((cnt_q[1:0] == 2'd3)
		? {{(ACC_W-32){word_q[31]}}, word_q}
		: {{(ACC_W-65){pfl[64]}}, pfl});
	assign w_sum = acc_q + {{(ACC_W-65){pfl[64]}}, pfl};

	assign op1_x = {{2{op_q[1][31]}}, op_q[1]};
	assign max_lo = {{2{aux_q[1][31]}}, aux_q[1]} - $signed({18'b0, eps_q});
	assign min_hi = {{2{aux_q[0][31]}}, aux_q[0]} + $signed({18'b0, eps_q});
	assign near = dist_q < DIST_ONE;

	assign sq_start = (state_q == S_CSQ_GO) || (state_q == S_LEN_GO);
	assign sq_rad = (state_q == S_CSQ_GO) ? dist_q : {2'b00, sum_q};

	sfn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign dv_start = (state_q == S_DV_GO);
	assign dv_num = (si_q == 2'd3) ? '0
		: {1'b0, mag_q[si_q][29:0], 30'b0} + NUM_W'(len_q[30:1]);

	sfn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (len_q),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	assign q_cap = (dv_quo > Q30_ONE) ? Q30_ONE : dv_quo;
	assign u_next = ((si_q != 2'd3) && w_q[si_q][ACC_W-1]) ? -$signed({1'b0, q_cap})
		: $signed({1'b0, q_cap});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			eps_q       <= 16'd7;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				eps_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						base_q <= in_base;
						pt_q[0] <= point_x;
						pt_q[1] <= point_y;
						pt_q[2] <= point_z;
						for (int i = 0; i < 3; i++) begin
							u_q[i] <= '0;
						end
						if (!mode) begin
							st_q    <= ST_STORED;
							state_q <= S_FIN;
						end else if (!obj_ok) begin
							st_q    <= ST_BAD_TYPE;
							state_q <= S_FIN;
						end else begin
							state_q <= S_TY_RD;
						end
					end
				end
				S_TY_RD: state_q <= S_TY_CHK;
				S_TY_CHK: begin
					if (ram_rdata > 32'd3) begin
						st_q    <= ST_BAD_TYPE;
						state_q <= S_FIN;
					end else begin
						type_q  <= shape_t'(ram_rdata[1:0]);
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= S_PT_RD;
					end
				end
				S_PT_RD: state_q <= S_PT_MUL;
				S_PT_MUL: begin
					prod_q  <= mul_p;
					word_q  <= $signed(ram_rdata);
					state_q <= S_PT_ACC;
				end
				S_PT_ACC: begin
					if (cnt_q[1:0] == 2'd3) begin
						acc_q <= '0;
						if (pt_sum > ACC_W'(32'sh7fff_ffff)) begin
							op_q[cnt_q[3:2]] <= 32'sh7fff_ffff;
						end else if (pt_sum < -ACC_W'(33'sh0_8000_0000)) begin
							op_q[cnt_q[3:2]] <= 32'sh8000_0000;
						end else begin
							op_q[cnt_q[3:2]] <= pt_sum[31:0];
						end
					end else begin
						acc_q <= pt_sum;
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd11) begin
						mx_q    <= '0;
						state_q <= S_MX_RD;
					end else begin
						state_q <= S_PT_RD;
					end
				end
				S_MX_RD: state_q <= S_MX_WT;
				S_MX_WT: begin
					aux_q[mx_q] <= $signed(ram_rdata);
					mx_q <= mx_q + 3'd1;
					state_q <= (mx_q == 3'd4) ? S_D0 : S_MX_RD;
				end
				S_D0: begin
					prod_q  <= mul_p;
					state_q <= S_D1;
				end
				S_D1: begin
					dist_q  <= prod_q[63:0];
					prod_q  <= mul_p;
					state_q <= S_D2;
				end
				S_D2: begin
					dist_q  <= dist_q + prod_q[63:0];
					state_q <= S_NSEL;
				end
				S_NSEL: begin
					wi_q  <= '0;
					wj_q  <= '0;
					acc_q <= '0;
					if (type_q == SH_PLANE) begin
						n_q[0] <= '0;
						n_q[1] <= ONE;
						n_q[2] <= '0;
						state_q <= S_W_RD;
					end else if (type_q == SH_SPHERE) begin
						for (int i = 0; i < 3; i++) begin
							n_q[i] <= {op_q[i][31], op_q[i]} - {aux_q[2+i][31], aux_q[2+i]};
						end
						state_q <= S_W_RD;
					end else if (near && (op1_x >= max_lo)) begin
						n_q[0] <= '0;
						n_q[1] <= ONE;
						n_q[2] <= '0;
						state_q <= S_W_RD;
					end else if (near && (op1_x <= min_hi)) begin
						n_q[0] <= '0;
						n_q[1] <= -ONE;
						n_q[2] <= '0;
						state_q <= S_W_RD;
					end else begin
						n_q[0] <= {op_q[0][31], op_q[0]};
						n_q[1] <= '0;
						n_q[2] <= {op_q[2][31], op_q[2]};
						state_q <= (type_q == SH_CONE) ? S_CSQ_GO : S_W_RD;
					end
				end
				S_CSQ_GO: state_q <= S_CSQ_WT;
				S_CSQ_WT: begin
					if (sq_done) begin
						n_q[1] <= (op_q[1] > 32'sd0) ? -$signed({1'b0, sq_root})
							: $signed({1'b0, sq_root});
						state_q <= S_W_RD;
					end
				end
				S_W_RD: state_q <= S_W_MUL;
				S_W_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_W_ACC;
				end
				S_W_ACC: begin
					if (wi_q == 2'd2) begin
						w_q[wj_q] <= w_sum;
						acc_q <= '0;
						wi_q  <= '0;
						wj_q  <= wj_q + 2'd1;
						state_q <= (wj_q == 2'd2) ? S_MAG : S_W_RD;
					end else begin
						acc_q <= w_sum;
						wi_q  <= wi_q + 2'd1;
						state_q <= S_W_RD;
					end
				end
				S_MAG: begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= w_q[i][ACC_W-1] ? ACC_W'(-w_q[i]) : ACC_W'(w_q[i]);
					end
					state_q <= S_MAX;
				end
				S_MAX: begin
					if (mag_q[0] >= mag_q[1] && mag_q[0] >= mag_q[2]) begin
						m_q <= mag_q[0];
					end else if (mag_q[1] >= mag_q[2]) begin
						m_q <= mag_q[1];
					end else begin
						m_q <= mag_q[2];
					end
					if (mag_q[0] == '0 && mag_q[1] == '0 && mag_q[2] == '0) begin
						st_q    <= ST_ZERO;
						state_q <= S_FIN;
					end else begin
						state_q <= S_NSH;
					end
				end
				S_NSH: begin
					if (m_q >= (ACC_W'(1) << 30)) begin
						m_q <= m_q >> 1;
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= mag_q[i] >> 1;
						end
					end else if (m_q < (ACC_W'(1) << 29)) begin
						m_q <= m_q << 1;
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= mag_q[i] << 1;
						end
					end else begin
						sum_q   <= '0;
						si_q    <= '0;
						state_q <= S_SQ_MUL;
					end
				end
				S_SQ_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_SQ_ACC;
				end
				S_SQ_ACC: begin
					sum_q <= sum_q + prod_q[61:0];
					si_q  <= si_q + 2'd1;
					state_q <= (si_q == 2'd2) ? S_LEN_GO : S_SQ_MUL;
				end
				S_LEN_GO: state_q <= S_LEN_WT;
				S_LEN_WT: begin
					if (sq_done) begin
						len_q   <= sq_root[30:0];
						si_q    <= '0;
						state_q <= S_DV_GO;
					end
				end
				S_DV_GO: state_q <= S_DV_WT;
				S_DV_WT: begin
					if (dv_done) begin
						u_q[si_q] <= u_next;
						si_q <= si_q + 2'd1;
						if (si_q == 2'd2) begin
							st_q    <= ST_OK;
							state_q <= S_FIN;
						end else begin
							state_q <= S_DV_GO;
						end
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						nx_q  <= u_q[0];
						ny_q  <= u_q[1];
						nz_q  <= u_q[2];
						ost_q <= st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign normal_x = nx_q;
	assign normal_y = ny_q;
	assign normal_z = nz_q;
	assign status = ost_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("a second transfer was taken while an item was in progress");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
		else $error("normal is not zero on a store or error result");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |-> normal_x != 0 || normal_y != 0 || normal_z != 0)
		else $error("valid normal is all zero");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= 32'sh4000_0000 && normal_x >= -32'sh4000_0000
			&& normal_y <= 32'sh4000_0000 && normal_y >= -32'sh4000_0000)
		else $error("normal component exceeds one");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DV_GO |-> len_q >= 31'h2000_0000)
		else $error("divisor below the normalized range");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Surface normal unit testbench
// Loads shape table slots with store transfers and sends hit points to them,
// covering planes, spheres, cones, cylinders, the flat caps, unknown types and
// zero-length normals. A predictor in this module tracks the shape table and
// epsilon and computes every expected normal and status. Both channels idle
// at random, and the epsilon register moves through several settings.
// ----------------------------------------------------------------------------
module tb;
	import sfn_pkg::*;

	localparam int SLOTS = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int PHASE_ITEMS = 235;

	typedef struct {
		logic        mode;
		logic [3:0]  obj;
		logic [4:0]  widx;
		logic [31:0] wval;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} hit_item_t;

	typedef struct {
		logic [31:0] nx;
		logic [31:0] ny;
		logic [31:0] nz;
		status_t     st;
	} normal_res_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic [3:0] object_id = '0;
	logic [4:0] word_index = '0;
	logic signed [31:0] word_value = '0;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] normal_x;
	logic signed [31:0] normal_y;
	logic signed [31:0] normal_z;
	logic [1:0] status;

	surface_normal_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .object_id(object_id), .word_index(word_index),
		.word_value(word_value), .point_x(point_x), .point_y(point_y),
		.point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.status(status)
	);

	hit_item_t pending_items[$];
	normal_res_t expected_normals[$];
	logic [31:0] shape_words[SLOTS * WORDS];
	logic [15:0] cur_epsilon = 16'd7;
	int errors = 0;
	bit in_taken = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int recv_hold = 0;
	int idle_cycles = 0;

	// Generator's view of each slot, used to aim hit points.
	logic [17:0] slot_written[SLOTS];
	bit slot_identity[SLOTS];
	int slot_min[SLOTS];
	int slot_max[SLOTS];
	int item_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint slot_word(int base, int k);
		return longint'($signed(shape_words[base + k]));
	endfunction

	function automatic normal_res_t predict_normal(hit_item_t it);
		normal_res_t r;
		int base;
		longint pt[3], op[3], n[3], w[3], acc;
		longint unsigned dist_sq, mag[3], m, sum, len, q;
		logic [31:0] shape;
		longint unsigned one_sq;
		r.nx = '0; r.ny = '0; r.nz = '0;
		one_sq = 64'd1 << 32;
		if (it.mode == 1'b0) begin
			if (it.widx < WORDS) shape_words[it.obj * WORDS + it.widx] = it.wval;
			r.st = ST_STORED;
			return r;
		end
		base = it.obj * WORDS;
		shape = shape_words[base + W_TYPE];
		if (shape > 32'd3) begin
			r.st = ST_BAD_TYPE;
			return r;
		end
		pt[0] = longint'($signed(it.px));
		pt[1] = longint'($signed(it.py));
		pt[2] = longint'($signed(it.pz));
		for (int i = 0; i < 3; i++) begin
			acc = slot_word(base, 4 * i + 3);
			for (int j = 0; j < 3; j++) acc += (slot_word(base, 4 * i + j) * pt[j]) >>> 16;
			if (acc > 64'sd2147483647) acc = 64'sd2147483647;
			if (acc < -64'sd2147483648) acc = -64'sd2147483648;
			op[i] = acc;
		end
		dist_sq = longint'(op[0] * op[0]) + longint'(op[2] * op[2]);
		if (shape == SH_PLANE) begin
			n[0] = 0; n[1] = 64'sd65536; n[2] = 0;
		end else if (shape == SH_SPHERE) begin
			for (int i = 0; i < 3; i++) n[i] = op[i] - slot_word(base, 15 + i);
		end else if (dist_sq < one_sq
				&& op[1] >= slot_word(base, 14) - longint'(cur_epsilon)) begin
			n[0] = 0; n[1] = 64'sd65536; n[2] = 0;
		end else if (dist_sq < one_sq
				&& op[1] <= slot_word(base, 13) + longint'(cur_epsilon)) begin
			n[0] = 0; n[1] = -64'sd65536; n[2] = 0;
		end else begin
			n[0] = op[0];
			n[2] = op[2];
			if (shape == SH_CONE) begin
				n[1] = longint'(floor_sqrt(dist_sq));
				if (op[1] > 0) n[1] = -n[1];
			end else begin
				n[1] = 0;
			end
		end
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int i = 0; i < 3; i++) acc += (slot_word(base, 4 * i + j) * n[i]) >>> 16;
			w[j] = acc;
		end
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = w[i] < 0 ? longint'(-w[i]) : longint'(w[i]);
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			r.st = ST_ZERO;
			return r;
		end
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
		len = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << 30) + (len >> 1)) / len;
			if (q > (64'd1 << 30)) q = 64'd1 << 30;
			n[i] = w[i] < 0 ? -longint'(q) : longint'(q);
		end
		r.nx = n[0][31:0];
		r.ny = n[1][31:0];
		r.nz = n[2][31:0];
		r.st = ST_OK;
		return r;
	endfunction

	task automatic push_store(int obj, int widx, logic [31:0] val);
		hit_item_t it;
		it.mode = 1'b0;
		it.obj = obj[3:0];
		it.widx = widx[4:0];
		it.wval = val;
		it.px = $urandom;
		it.py = $urandom;
		it.pz = $urandom;
		if (widx < WORDS) slot_written[obj][widx] = 1'b1;
		pending_items.push_back(it);
		item_count++;
	endtask

	task automatic push_hit(int obj, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		hit_item_t it;
		it.mode = 1'b1;
		it.obj = obj[3:0];
		it.widx = $urandom;
		it.wval = $urandom;
		it.px = x;
		it.py = y;
		it.pz = z;
		pending_items.push_back(it);
		item_count++;
	endtask

	function automatic logic [31:0] rand_small(int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	// kind: 0 identity, 1 small random matrix, 2 full random matrix, 3 all zero
	task automatic load_slot(int obj, int kind, logic [31:0] shape);
		logic [31:0] v;
		int lo, hi;
		lo = -int'($urandom_range(0, 5)) * 65536 - int'($urandom_range(0, 65535));
		hi = int'($urandom_range(0, 5)) * 65536 + int'($urandom_range(0, 65535));
		slot_identity[obj] = (kind == 0);
		slot_min[obj] = lo;
		slot_max[obj] = hi;
		for (int k = 0; k < 12; k++) begin
			case (kind)
				0: v = (k % 4 == k / 4) ? 32'h0001_0000 : 32'h0;
				1: v = (k % 4 == 3) ? rand_small(1 << 20) : rand_small(1 << 17);
				2: v = $urandom;
				default: v = 32'h0;
			endcase
			push_store(obj, k, v);
		end
		push_store(obj, W_TYPE, shape);
		push_store(obj, W_MIN, lo);
		push_store(obj, 14, hi);
		for (int k = 15; k < WORDS; k++)
			push_store(obj, k, ($urandom_range(0, 9) == 0) ? $urandom : rand_small(1 << 18));
	endtask

	task automatic aimed_hit(int obj);
		longint yv;
		int sel;
		sel = $urandom_range(0, 9);
		if (slot_identity[obj] && sel < 5) begin
			yv = ($urandom_range(0, 1) == 0) ? slot_max[obj] : slot_min[obj];
			yv += longint'($urandom_range(0, 2 * int'(cur_epsilon) + 2)) - cur_epsilon - 1;
			if (sel == 0)
				push_hit(obj, 32'h0, yv[31:0], 32'h0);
			else
				push_hit(obj, rand_small(1 << 15), yv[31:0], rand_small(1 << 15));
		end else if (sel < 8) begin
			push_hit(obj, rand_small(1 << 20), rand_small(1 << 20), rand_small(1 << 20));
		end else begin
			push_hit(obj, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic random_shape(output logic [31:0] shape);
		if ($urandom_range(0, 9) == 0) shape = $urandom | 32'h4;
		else shape = $urandom_range(0, 3);
	endtask

	task automatic fill_phase(int count);
		int start, full[$];
		logic [31:0] shape;
		start = item_count;
		while (item_count - start < count) begin
			full.delete();
			for (int s = 0; s < SLOTS; s++) if (&slot_written[s]) full.push_back(s);
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					random_shape(shape);
					load_slot($urandom_range(0, SLOTS - 1), $urandom_range(0, 3), shape);
				end
				3: push_store($urandom_range(0, SLOTS - 1), $urandom_range(0, 31), $urandom);
				default: begin
					if (full.size() != 0) aimed_hit(full[$urandom_range(0, full.size() - 1)]);
				end
			endcase
		end
	endtask

	task automatic drain_block();
		while (pending_items.size() != 0 || in_valid || expected_normals.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_epsilon(logic [15:0] v);
		drain_block();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_epsilon = v;
	endtask

	initial begin
		logic [15:0] eps_list[4];
		for (int s = 0; s < SLOTS; s++) slot_written[s] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Out-of-range stores, then one slot per shape type, an all-zero cylinder and an unknown type.
		push_store(15, 31, 32'h8000_0000);
		push_store(0, 18, 32'h7FFF_FFFF);
		load_slot(0, 0, SH_PLANE);
		load_slot(1, 0, SH_SPHERE);
		load_slot(2, 0, SH_CONE);
		load_slot(3, 0, SH_CYL);
		load_slot(4, 3, SH_CYL);
		load_slot(5, 1, 32'hFFFF_FFFF);
		push_hit(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		push_hit(1, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
		push_hit(2, 32'h0003_0000, 32'h0001_0000, 32'h0004_0000);
		push_hit(3, 32'h0003_0000, 32'h0001_0000, 32'h0004_0000);
		push_hit(3, 32'h0, slot_max[3], 32'h0);
		push_hit(3, 32'h0000_8000, slot_min[3], 32'h0);
		push_hit(3, 32'h0, 32'h0, 32'h0);
		push_hit(4, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		push_hit(5, 32'h0, 32'h0, 32'h0);
		fill_phase(PHASE_ITEMS);

		eps_list = '{16'd0, 16'hFFFF, 16'd0, 16'd1000};
		eps_list[2] = $urandom;
		for (int p = 0; p < 4; p++) begin
			write_epsilon(eps_list[p]);
			if (p == 1) recv_hold = 3000;
			fill_phase(PHASE_ITEMS);
		end

		drain_block();
		repeat (50) @(posedge clk);
		if (errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end

	// Monitor: records input transfers and checks output transfers.
	always @(posedge clk) begin
		normal_res_t want;
		if (in_valid && in_ready) begin
			expected_normals.push_back(predict_normal('{mode, object_id, word_index,
				word_value, point_x, point_y, point_z}));
			in_taken = 1;
		end
		if (out_valid && out_ready) begin
			if (expected_normals.size() == 0) begin
				$error("unexpected result transfer, status %0d", status);
				errors++;
			end else begin
				want = expected_normals.pop_front();
				if (normal_x !== want.nx) begin
					$error("normal_x expected %0d actual %0d", $signed(want.nx), normal_x);
					errors++;
				end
				if (normal_y !== want.ny) begin
					$error("normal_y expected %0d actual %0d", $signed(want.ny), normal_y);
					errors++;
				end
				if (normal_z !== want.nz) begin
					$error("normal_z expected %0d actual %0d", $signed(want.nz), normal_z);
					errors++;
				end
				if (status !== want.st) begin
					$error("status expected %0d actual %0d", want.st, status);
					errors++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Driver: offers the next pending item after a random gap.
	always @(negedge clk) begin
		hit_item_t it;
		if (!in_valid || in_taken) begin
			in_taken = 0;
			if (send_gap > 0 || pending_items.size() == 0) begin
				if (send_gap > 0) send_gap--;
				in_valid <= 1'b0;
			end else begin
				it = pending_items.pop_front();
				in_valid <= 1'b1;
				mode <= it.mode;
				object_id <= it.obj;
				word_index <= it.widx;
				word_value <= it.wval;
				point_x <= it.px;
				point_y <= it.py;
				point_z <= it.pz;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: send_gap = 0;
					9: send_gap = $urandom_range(20, 80);
					default: send_gap = $urandom_range(1, 3);
				endcase
			end
		end
	end

	// Receiver: random stalls, and one long hold-off on request.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold--;
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			case ($urandom_range(0, 15))
				0: recv_gap = $urandom_range(20, 120);
				1, 2, 3, 4: recv_gap = $urandom_range(1, 4);
				default: recv_gap = 0;
			endcase
		end
	end

endmodule
